### rtl/fafp_pkg.sv
// ----------------------------------------------------------------------------
// fafp_pkg: shared types and constants for the five-axis forward position block
// Trig lane constants, rotation matrix bundle, Q30 multiply helper.
// ----------------------------------------------------------------------------
package fafp_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int TRIG_W       = 32;   // sine/cosine, Q30 signed
  localparam int ENT_W        = 34;   // matrix entry, Q30 signed with headroom
  localparam int OFF_W        = 21;   // tool z offset

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // Sines and cosines of the four joints
  typedef struct packed {
    logic signed [TRIG_W-1:0] sr;
    logic signed [TRIG_W-1:0] cr;
    logic signed [TRIG_W-1:0] st;
    logic signed [TRIG_W-1:0] ct;
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] cp;
    logic signed [TRIG_W-1:0] ss;
    logic signed [TRIG_W-1:0] cs;
  } trig_t;

  // Rotation matrix plus the theta terms used by the offset correction
  typedef struct packed {
    logic signed [ENT_W-1:0] r00;
    logic signed [ENT_W-1:0] r01;
    logic signed [ENT_W-1:0] r02;
    logic signed [ENT_W-1:0] r10;
    logic signed [ENT_W-1:0] r11;
    logic signed [ENT_W-1:0] r12;
    logic signed [ENT_W-1:0] r20;
    logic signed [ENT_W-1:0] r21;
    logic signed [ENT_W-1:0] r22;
    logic signed [ENT_W-1:0] st;
    logic signed [ENT_W-1:0] ct;
  } rot_t;

  // CORDIC arctangent table, 2^30 = pi/2
  function automatic logic signed [TRIG_W-1:0] atan_at(input logic [4:0] idx);
    logic signed [TRIG_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sd536870912;
      5'd1:    v = 32'sd316933406;
      5'd2:    v = 32'sd167458907;
      5'd3:    v = 32'sd85004756;
      5'd4:    v = 32'sd42667331;
      5'd5:    v = 32'sd21354465;
      5'd6:    v = 32'sd10679838;
      5'd7:    v = 32'sd5340245;
      5'd8:    v = 32'sd2670163;
      5'd9:    v = 32'sd1335087;
      5'd10:   v = 32'sd667544;
      5'd11:   v = 32'sd333772;
      5'd12:   v = 32'sd166886;
      5'd13:   v = 32'sd83443;
      5'd14:   v = 32'sd41722;
      5'd15:   v = 32'sd20861;
      5'd16:   v = 32'sd10430;
      5'd17:   v = 32'sd5215;
      5'd18:   v = 32'sd2608;
      5'd19:   v = 32'sd1304;
      5'd20:   v = 32'sd652;
      5'd21:   v = 32'sd326;
      5'd22:   v = 32'sd163;
      5'd23:   v = 32'sd81;
      5'd24:   v = 32'sd41;
      5'd25:   v = 32'sd20;
      5'd26:   v = 32'sd10;
      5'd27:   v = 32'sd5;
      5'd28:   v = 32'sd3;
      5'd29:   v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q30 product, rounded half up (floor after adding half an LSB)
  function automatic logic signed [ENT_W-1:0] mul30(input logic signed [ENT_W-1:0] a,
                                                    input logic signed [ENT_W-1:0] b);
    logic signed [2*ENT_W-1:0] p;
    p = a * b;
    p = p + (2*ENT_W)'(64'h2000_0000);
    return p[ENT_W+29:30];
  endfunction

endpackage

### rtl/fafp_cordic.sv
// ----------------------------------------------------------------------------
// fafp_cordic: pipelined sine/cosine of one binary angle
// Seed stage, one CORDIC iteration per stage, then a quadrant fold. 32 stages.
// ----------------------------------------------------------------------------
module fafp_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [ANGLE_BITS-1:0]           angle,
  output logic signed [fafp_pkg::TRIG_W-1:0]     sin_o,
  output logic signed [fafp_pkg::TRIG_W-1:0]     cos_o
);

  localparam int STEPS = fafp_pkg::CORDIC_STEPS;
  localparam int TW    = fafp_pkg::TRIG_W;

  logic [31:0]          phase;
  logic signed [TW-1:0] x_r [STEPS+1];
  logic signed [TW-1:0] y_r [STEPS+1];
  logic signed [TW-1:0] z_r [STEPS+1];
  logic [1:0]           q_r [STEPS+1];
  logic signed [TW-1:0] sin_r, cos_r;

  // angle scaled to a full-turn 32-bit phase
  assign phase = {angle, {(32-ANGLE_BITS){1'b0}}};

  // seed stage
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= fafp_pkg::CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= {2'b00, phase[29:0]};
      q_r[0] <= phase[31:30];
    end
  end

  // rotation stages
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][TW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - fafp_pkg::atan_at(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + fafp_pkg::atan_at(5'(i));
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      case (fafp_pkg::quad_t'(q_r[STEPS]))
        fafp_pkg::QUAD_0: begin
          cos_r <= x_r[STEPS];
          sin_r <= y_r[STEPS];
        end
        fafp_pkg::QUAD_1: begin
          cos_r <= -y_r[STEPS];
          sin_r <= x_r[STEPS];
        end
        fafp_pkg::QUAD_2: begin
          cos_r <= -x_r[STEPS];
          sin_r <= -y_r[STEPS];
        end
        default: begin
          cos_r <= y_r[STEPS];
          sin_r <= -x_r[STEPS];
        end
      endcase
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### rtl/fafp_matrix.sv
// ----------------------------------------------------------------------------
// fafp_matrix: rotation matrix from the joint sines and cosines
// Three stages, one Q30 multiply level each with the adds that follow it.
// ----------------------------------------------------------------------------
module fafp_matrix (
  input  logic             clk,
  input  logic             en,
  input  fafp_pkg::trig_t  trig,
  output fafp_pkg::rot_t   rot
);

  localparam int EW = fafp_pkg::ENT_W;

  logic signed [EW-1:0] sr, cr, st, ct, sp, cp, ss, cs;

  // stage 1 products
  logic signed [EW-1:0] cpct_r, crst_r, cpsr_r, crct_r, cpcr_r, srst_r, csct_r;
  logic signed [EW-1:0] ctsp_r, crsp_r, cpcs_r, spss_r, cssp_r, cpss_r, ctsr_r;
  logic signed [EW-1:0] sr1_r, st1_r, ct1_r, sp1_r, ss1_r, cs1_r;

  // stage 2 partial entries
  logic signed [EW-1:0] a2_r, b2_r, r00_2_r, r01p_r, r02p_r, r10_2_r;
  logic signed [EW-1:0] r11_2_r, r12_2_r, r20_2_r, r21p_r, r22p_r;
  logic signed [EW-1:0] ss2_r, cs2_r, st2_r, ct2_r;

  // stage 3 complete matrix
  fafp_pkg::rot_t rot_r;

  assign sr = EW'(trig.sr);
  assign cr = EW'(trig.cr);
  assign st = EW'(trig.st);
  assign ct = EW'(trig.ct);
  assign sp = EW'(trig.sp);
  assign cp = EW'(trig.cp);
  assign ss = EW'(trig.ss);
  assign cs = EW'(trig.cs);

  // pairwise products of the raw terms
  always_ff @(posedge clk) begin
    if (en) begin
      cpct_r <= fafp_pkg::mul30(cp, ct);
      crst_r <= fafp_pkg::mul30(cr, st);
      cpsr_r <= fafp_pkg::mul30(cp, sr);
      crct_r <= fafp_pkg::mul30(cr, ct);
      cpcr_r <= fafp_pkg::mul30(cp, cr);
      srst_r <= fafp_pkg::mul30(sr, st);
      csct_r <= fafp_pkg::mul30(cs, ct);
      ctsp_r <= fafp_pkg::mul30(ct, sp);
      crsp_r <= fafp_pkg::mul30(cr, sp);
      cpcs_r <= fafp_pkg::mul30(cp, cs);
      spss_r <= fafp_pkg::mul30(sp, ss);
      cssp_r <= fafp_pkg::mul30(cs, sp);
      cpss_r <= fafp_pkg::mul30(cp, ss);
      ctsr_r <= fafp_pkg::mul30(ct, sr);
      sr1_r  <= sr;
      st1_r  <= st;
      ct1_r  <= ct;
      sp1_r  <= sp;
      ss1_r  <= ss;
      cs1_r  <= cs;
    end
  end

  // triple products and the entries they finish
  always_ff @(posedge clk) begin
    if (en) begin
      a2_r    <= crst_r + fafp_pkg::mul30(cpct_r, sr1_r);
      b2_r    <= crct_r - fafp_pkg::mul30(cpsr_r, st1_r);
      r00_2_r <= fafp_pkg::mul30(cpcr_r, ct1_r) - srst_r;
      r01p_r  <= -fafp_pkg::mul30(csct_r, sp1_r);
      r02p_r  <= fafp_pkg::mul30(ctsp_r, ss1_r);
      r10_2_r <= crsp_r;
      r11_2_r <= cpcs_r + fafp_pkg::mul30(spss_r, sr1_r);
      r12_2_r <= fafp_pkg::mul30(cssp_r, sr1_r) - cpss_r;
      r20_2_r <= -(ctsr_r + fafp_pkg::mul30(cpcr_r, st1_r));
      r21p_r  <= fafp_pkg::mul30(cssp_r, st1_r);
      r22p_r  <= -fafp_pkg::mul30(spss_r, st1_r);
      ss2_r   <= ss1_r;
      cs2_r   <= cs1_r;
      st2_r   <= st1_r;
      ct2_r   <= ct1_r;
    end
  end

  // psi terms against the A and B sums
  always_ff @(posedge clk) begin
    if (en) begin
      rot_r.r00 <= r00_2_r;
      rot_r.r01 <= fafp_pkg::mul30(ss2_r, a2_r) + r01p_r;
      rot_r.r02 <= fafp_pkg::mul30(cs2_r, a2_r) + r02p_r;
      rot_r.r10 <= r10_2_r;
      rot_r.r11 <= r11_2_r;
      rot_r.r12 <= r12_2_r;
      rot_r.r20 <= r20_2_r;
      rot_r.r21 <= fafp_pkg::mul30(ss2_r, b2_r) + r21p_r;
      rot_r.r22 <= fafp_pkg::mul30(cs2_r, b2_r) + r22p_r;
      rot_r.st  <= st2_r;
      rot_r.ct  <= ct2_r;
    end
  end

  assign rot = rot_r;

endmodule

### rtl/fafp_project.sv
// ----------------------------------------------------------------------------
// fafp_project: applies the rotation to the plate point and adds the offsets
// Stage 1 forms the rounded products, stage 2 sums each axis.
// ----------------------------------------------------------------------------
module fafp_project #(
  parameter int COORD_BITS = 24,
  parameter int SUM_W      = COORD_BITS + 8
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  fafp_pkg::rot_t                         rot,
  input  logic signed [COORD_BITS-1:0]           frame [3],
  input  logic signed [COORD_BITS-1:0]           plate [3],
  input  logic signed [fafp_pkg::OFF_W-1:0]      off,
  output logic signed [SUM_W-1:0]                sum_o [3]
);

  localparam int EW   = fafp_pkg::ENT_W;
  localparam int OW   = fafp_pkg::OFF_W;
  localparam int PW   = COORD_BITS + EW;
  localparam int PR_W = PW - 30;
  localparam int QW   = OW + EW;
  localparam int QR_W = QW - 30;

  // coordinate times entry, rounded Q30
  function automatic logic signed [PR_W-1:0] mulc(input logic signed [COORD_BITS-1:0] c,
                                                  input logic signed [EW-1:0] e);
    logic signed [PW-1:0] p;
    p = c * e;
    p = p + PW'(64'h2000_0000);
    return p[PW-1:30];
  endfunction

  // offset times entry, rounded Q30
  function automatic logic signed [QR_W-1:0] mulo(input logic signed [OW-1:0] o,
                                                  input logic signed [EW-1:0] e);
    logic signed [QW-1:0] p;
    p = o * e;
    p = p + QW'(64'h2000_0000);
    return p[QW-1:30];
  endfunction

  logic signed [PR_W-1:0]       px_r [3];
  logic signed [PR_W-1:0]       py_r [3];
  logic signed [PR_W-1:0]       pz_r [3];
  logic signed [QR_W-1:0]       ost_r, oct_r;
  logic signed [COORD_BITS-1:0] frame_r [3];
  logic signed [OW-1:0]         off_r;
  logic signed [SUM_W-1:0]      sum_r [3];

  // rounded products
  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0]    <= mulc(plate[0], rot.r00);
      py_r[0]    <= mulc(plate[1], rot.r01);
      pz_r[0]    <= mulc(plate[2], rot.r02);
      px_r[1]    <= mulc(plate[0], rot.r10);
      py_r[1]    <= mulc(plate[1], rot.r11);
      pz_r[1]    <= mulc(plate[2], rot.r12);
      px_r[2]    <= mulc(plate[0], rot.r20);
      py_r[2]    <= mulc(plate[1], rot.r21);
      pz_r[2]    <= mulc(plate[2], rot.r22);
      ost_r      <= mulo(off, rot.st);
      oct_r      <= mulo(off, rot.ct);
      frame_r[0] <= frame[0];
      frame_r[1] <= frame[1];
      frame_r[2] <= frame[2];
      off_r      <= off;
    end
  end

  // per-axis sums
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r[0] <= SUM_W'(frame_r[0]) + SUM_W'(px_r[0]) + SUM_W'(py_r[0])
                + SUM_W'(pz_r[0]) - SUM_W'(ost_r);
      sum_r[1] <= SUM_W'(frame_r[1]) + SUM_W'(px_r[1]) + SUM_W'(py_r[1])
                + SUM_W'(pz_r[1]);
      sum_r[2] <= SUM_W'(off_r) + SUM_W'(frame_r[2]) + SUM_W'(px_r[2])
                + SUM_W'(py_r[2]) + SUM_W'(pz_r[2]) - SUM_W'(oct_r);
    end
  end

  assign sum_o = sum_r;

endmodule

### rtl/five_axis_forward_position.sv
// ----------------------------------------------------------------------------
// five_axis_forward_position: tool-frame point of a five-axis head
// An input transfer passes 32 CORDIC stages, 3 matrix stages and 2 projection
// stages, then the output register.
// Throughput: one point per cycle; a stalled output holds the pipeline only
// when its last stage is full. Reset (rst_n low, synchronous) clears all
// valid bits and the tool z offset.
// ----------------------------------------------------------------------------
module five_axis_forward_position #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tool_z_offset
  input  logic                            cfg_wen,
  input  logic [fafp_pkg::OFF_W-1:0]      cfg_wdata,
  // frame_x, frame_y, frame_z, plate_x, plate_y, plate_z,
  // angle_rho, angle_theta, angle_phi, angle_psi (lowest first)
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [((6*COORD_BITS+4*ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  // pos_x, pos_y, pos_z (lowest first)
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((3*(COORD_BITS+2)+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_W  = COORD_BITS + 2;
  localparam int OUT_TW = ((3*OUT_W+7)/8)*8;
  localparam int SUM_W  = COORD_BITS + 8;
  localparam int CORD_D = fafp_pkg::CORDIC_STEPS + 2;
  localparam int DLY    = CORD_D + 3;          // coords meet the finished matrix
  localparam int NSTG   = DLY + 2;
  localparam int LAST   = NSTG - 1;

  localparam logic signed [SUM_W-1:0] OUT_MAX =
    {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] OUT_MIN =
    {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic                                en;
  logic                                out_load;
  logic [NSTG-1:0]                     v_r;
  logic                                out_valid_r;
  logic signed [fafp_pkg::OFF_W-1:0]   off_r;
  logic signed [COORD_BITS-1:0]        coord [6];
  logic signed [ANGLE_BITS-1:0]        angle [4];
  logic signed [COORD_BITS-1:0]        dly_r [DLY][6];
  logic signed [COORD_BITS-1:0]        frame_d [3];
  logic signed [COORD_BITS-1:0]        plate_d [3];
  logic signed [fafp_pkg::TRIG_W-1:0]  sin_w [4];
  logic signed [fafp_pkg::TRIG_W-1:0]  cos_w [4];
  fafp_pkg::trig_t                     trig;
  fafp_pkg::rot_t                      rot;
  logic signed [SUM_W-1:0]             sum [3];
  logic signed [OUT_W-1:0]             pos_r [3];

  // handshake: the pipe moves when the output takes its last stage or it is empty
  assign out_load  = !out_valid_r || out_tready;
  assign en        = out_load || !v_r[LAST];
  assign in_tready = en;

  // unpack the input transfer
  for (genvar k = 0; k < 6; k++) begin : g_coord
    assign coord[k] = in_tdata[k*COORD_BITS +: COORD_BITS];
  end
  for (genvar j = 0; j < 4; j++) begin : g_angle
    assign angle[j] = in_tdata[6*COORD_BITS + j*ANGLE_BITS +: ANGLE_BITS];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (cfg_wen) begin
      off_r <= cfg_wdata;
    end
  end

  // valid bits along the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_tvalid};
    end
  end

  // coordinate delay line up to the projection stage
  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= coord;
      for (int s = 1; s < DLY; s++) begin
        dly_r[s] <= dly_r[s-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_split
    assign frame_d[k] = dly_r[DLY-1][k];
    assign plate_d[k] = dly_r[DLY-1][k+3];
  end

  // one CORDIC lane per joint
  for (genvar j = 0; j < 4; j++) begin : g_lane
    fafp_cordic #(
      .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
      .clk   (clk),
      .en    (en),
      .angle (angle[j]),
      .sin_o (sin_w[j]),
      .cos_o (cos_w[j])
    );
  end

  assign trig.sr = sin_w[0];
  assign trig.cr = cos_w[0];
  assign trig.st = sin_w[1];
  assign trig.ct = cos_w[1];
  assign trig.sp = sin_w[2];
  assign trig.cp = cos_w[2];
  assign trig.ss = sin_w[3];
  assign trig.cs = cos_w[3];

  fafp_matrix u_matrix (
    .clk  (clk),
    .en   (en),
    .trig (trig),
    .rot  (rot)
  );

  fafp_project #(
    .COORD_BITS (COORD_BITS),
    .SUM_W      (SUM_W)
  ) u_project (
    .clk   (clk),
    .en    (en),
    .rot   (rot),
    .frame (frame_d),
    .plate (plate_d),
    .off   (off_r),
    .sum_o (sum)
  );

  // output register with saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int a = 0; a < 3; a++) begin
        if (sum[a] > OUT_MAX) begin
          pos_r[a] <= OUT_MAX[OUT_W-1:0];
        end else if (sum[a] < OUT_MIN) begin
          pos_r[a] <= OUT_MIN[OUT_W-1:0];
        end else begin
          pos_r[a] <= sum[a][OUT_W-1:0];
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({pos_r[2], pos_r[1], pos_r[0]});

`ifndef SYNTH
  // an accepted item enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted transfer did not enter the pipe");

  // while stalled, no valid bit moves
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipe moved during a stall");

  // a full last stage behind a blocked output stops the input
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && v_r[LAST]) |-> !in_tready)
    else $error("input accepted with the pipe full and blocked");

  // the last stage moves into the output whenever the output frees up
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && v_r[LAST]) |=> out_valid_r)
    else $error("result lost at the output register");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: five_axis_forward_position
// Drives points with random angles and coordinates over the input stream,
// predicts each tool-frame point with a CORDIC and Q30 matrix model of its
// own, and compares every output transfer field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ABITS = 16;
  localparam int CBITS = 24;
  localparam int OBITS = CBITS + 2;
  localparam int IN_W  = ((6*CBITS+4*ABITS+7)/8)*8;
  localparam int OUT_W = ((3*OBITS+7)/8)*8;
  localparam int PIPE_LAT = 40;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CBITS-1:0] fx, fy, fz, px, py, pz;
    logic signed [ABITS-1:0] rho, theta, phi, psi;
  } point_t;

  typedef struct {
    logic signed [OBITS-1:0] x, y, z;
  } tool_pos_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wen = 1'b0;
  logic [fafp_pkg::OFF_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  longint offset_um = 0;
  tool_pos_t pos_queue[$];
  int errors = 0;
  int n_points = 0;
  int n_checked = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  int stall_pct = 30;

  five_axis_forward_position #(.ANGLE_BITS(ABITS), .COORD_BITS(CBITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // ---------------- prediction ----------------
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void cordic_sincos(logic [ABITS-1:0] code,
                                        output longint s, output longint c);
    logic [31:0] phase;
    longint x, y, z, nx, at;
    phase = {code, {(32-ABITS){1'b0}}};
    z = longint'(phase[29:0]);
    x = longint'(fafp_pkg::CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < fafp_pkg::CORDIC_STEPS; i++) begin
      at = longint'(fafp_pkg::atan_at(5'(i)));
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y  = y + floor_shift(x, i);
        z  = z - at;
      end else begin
        nx = x + floor_shift(y, i);
        y  = y - floor_shift(x, i);
        z  = z + at;
      end
      x = nx;
    end
    case (fafp_pkg::quad_t'(phase[31:30]))
      fafp_pkg::QUAD_0: begin c = x;  s = y;  end
      fafp_pkg::QUAD_1: begin c = -y; s = x;  end
      fafp_pkg::QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [OBITS-1:0] clamp_out(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (OBITS-1)) - 1;
    lo = -(64'sd1 <<< (OBITS-1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return OBITS'(v);
  endfunction

  function automatic tool_pos_t predict_tool_pos(point_t p, longint off);
    longint sr, cr, st, ct, sp, cp, ss, cs, a, b;
    longint r00, r01, r02, r10, r11, r12, r20, r21, r22, vx, vy, vz;
    tool_pos_t r;
    cordic_sincos(p.rho, sr, cr);
    cordic_sincos(p.theta, st, ct);
    cordic_sincos(p.phi, sp, cp);
    cordic_sincos(p.psi, ss, cs);
    a = q30(cr, st) + q30(q30(cp, ct), sr);
    b = q30(cr, ct) - q30(q30(cp, sr), st);
    r00 = q30(q30(cp, cr), ct) - q30(sr, st);
    r01 = q30(ss, a) - q30(q30(cs, ct), sp);
    r02 = q30(cs, a) + q30(q30(ct, sp), ss);
    r10 = q30(cr, sp);
    r11 = q30(cp, cs) + q30(q30(sp, ss), sr);
    r12 = q30(q30(cs, sp), sr) - q30(cp, ss);
    r20 = -(q30(ct, sr) + q30(q30(cp, cr), st));
    r21 = q30(ss, b) + q30(q30(cs, sp), st);
    r22 = q30(cs, b) - q30(q30(sp, ss), st);
    vx = longint'(p.fx) + q30(p.px, r00) + q30(p.py, r01) + q30(p.pz, r02) - q30(off, st);
    vy = longint'(p.fy) + q30(p.px, r10) + q30(p.py, r11) + q30(p.pz, r12);
    vz = off + longint'(p.fz) + q30(p.px, r20) + q30(p.py, r21) + q30(p.pz, r22)
         - q30(off, ct);
    r.x = clamp_out(vx);
    r.y = clamp_out(vy);
    r.z = clamp_out(vz);
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic point_t rand_point(bit wide);
    point_t p;
    p.fx = wide ? CBITS'($urandom) : CBITS'($urandom_range(0, 4000000) - 2000000);
    p.fy = wide ? CBITS'($urandom) : CBITS'($urandom_range(0, 4000000) - 2000000);
    p.fz = wide ? CBITS'($urandom) : CBITS'($urandom_range(0, 4000000) - 2000000);
    p.px = wide ? CBITS'($urandom) : CBITS'($urandom_range(0, 400000) - 200000);
    p.py = wide ? CBITS'($urandom) : CBITS'($urandom_range(0, 400000) - 200000);
    p.pz = wide ? CBITS'($urandom) : CBITS'($urandom_range(0, 400000) - 200000);
    p.rho = ABITS'($urandom);
    p.theta = ABITS'($urandom);
    p.phi = ABITS'($urandom);
    p.psi = ABITS'($urandom);
    return p;
  endfunction

  // one input transfer; prediction is made at acceptance, in_tvalid stays up
  task automatic send_point(point_t p);
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'({p.psi, p.phi, p.theta, p.rho, p.pz, p.py, p.px, p.fz, p.fy, p.fx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pos_queue.push_back(predict_tool_pos(p, offset_um));
    n_points++;
  endtask

  // bursts of back-to-back transfers with random gaps
  task automatic send_random(int count, int wide_pct);
    int burst, gap;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && count > 0; i++, count--)
        send_point(rand_point($urandom_range(0, 99) < wide_pct));
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5);
      if (count == 0 && gap == 0) gap = 1;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_and_write(logic signed [fafp_pkg::OFF_W-1:0] v);
    while (pos_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    offset_um = longint'(v);
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    tool_pos_t want;
    logic signed [OBITS-1:0] gx, gy, gz;
    if (rst_n && out_tvalid && out_tready) begin
      gx = out_tdata[OBITS-1:0];
      gy = out_tdata[2*OBITS-1:OBITS];
      gz = out_tdata[3*OBITS-1:2*OBITS];
      if (pos_queue.size() == 0) begin
        $error("unexpected output transfer");
        errors++;
      end else begin
        want = pos_queue.pop_front();
        n_checked++;
        if (gx !== want.x) begin $error("pos_x exp %0d got %0d", want.x, gx); errors++; end
        if (gy !== want.y) begin $error("pos_y exp %0d got %0d", want.y, gy); errors++; end
        if (gz !== want.z) begin $error("pos_z exp %0d got %0d", want.z, gz); errors++; end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** five_axis_forward_position: FAILED **");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_extremes();
    point_t p;
    logic signed [ABITS-1:0] angs[6];
    angs = '{16'sh0000, 16'sh4000, 16'sh8000, 16'shC000, 16'sh7FFF, 16'sh0001};
    // zero angles, extreme coordinates
    p = '{fx: 24'sh7FFFFF, fy: 24'sh800000, fz: 24'sh7FFFFF,
          px: 24'sh7FFFFF, py: 24'sh800000, pz: 24'sh7FFFFF,
          rho: 0, theta: 0, phi: 0, psi: 0};
    send_point(p);
    p.fx = 24'sh800000; p.fy = 24'sh7FFFFF; p.fz = 24'sh800000;
    p.px = 24'sh800000; p.py = 24'sh7FFFFF; p.pz = 24'sh800000;
    send_point(p);
    // quadrant boundaries and angle wrap at -pi
    foreach (angs[i]) begin
      p = rand_point(1'b1);
      p.rho = angs[i]; p.theta = angs[(i+1)%6]; p.phi = angs[(i+2)%6];
      p.psi = angs[(i+3)%6];
      send_point(p);
    end
    // saturation: all coordinates pushing the same way
    for (int i = 0; i < 4; i++) begin
      p = rand_point(1'b0);
      p.fx = 24'sh7FFFFF; p.fy = 24'sh7FFFFF; p.fz = 24'sh7FFFFF;
      p.px = 24'sh7FFFFF; p.py = 24'sh7FFFFF; p.pz = 24'sh7FFFFF;
      send_point(p);
      p.fx = 24'sh800000; p.fy = 24'sh800000; p.fz = 24'sh800000;
      p.px = 24'sh800000; p.py = 24'sh800000; p.pz = 24'sh800000;
      send_point(p);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_offsets();
    logic signed [fafp_pkg::OFF_W-1:0] offs[4];
    offs = '{21'sh0FFFFF, 21'sh100000, 21'sd12345, 21'sd0};
    foreach (offs[i]) begin
      drain_and_write(offs[i]);
      send_random(30, 40);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(80, 20);
    join
  endtask

  task automatic test_random_flow();
    stall_pct = 0;
    send_random(60, 25);
    stall_pct = 70;
    send_random(60, 25);
    stall_pct = 30;
    drain_and_write(fafp_pkg::OFF_W'($urandom));
    send_random(80, 25);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_offsets();
    test_backpressure();
    test_random_flow();
    while (pos_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
    $display("covered %0d points (%0d checked): extremes, quadrant edges, saturation,",
             n_points, n_checked);
    $display("offset extremes, long output hold-off and random flow control");
    if (errors == 0 && pos_queue.size() == 0)
      $display("** five_axis_forward_position: PASSED **");
    else
      $display("** five_axis_forward_position: FAILED **");
    $finish;
  end
endmodule

### files.f
rtl/fafp_pkg.sv
rtl/fafp_cordic.sv
rtl/fafp_matrix.sv
rtl/fafp_project.sv
rtl/five_axis_forward_position.sv
sim/testbench.sv
